[rtl/sfp_pkg.sv]
`default_nettype none
package sfp_pkg;

  localparam int SAMPLES_PER_FRAME = 10;
  localparam int SLOT_W = (SAMPLES_PER_FRAME > 1) ? $clog2(SAMPLES_PER_FRAME) : 1;

  localparam int SAMPLE_W = 24;
  localparam int AUX_W    = 16;
  localparam int BYTE_W   = 8;

  localparam logic [BYTE_W-1:0] START_MARK = 8'hAA;
  localparam logic [BYTE_W-1:0] STOP_MARK  = 8'h55;

  // header is two marks and the two counter bytes
  localparam logic [2:0] HDR_LAST    = 3'd3;
  localparam logic [2:0] SAMPLE_LAST = 3'd2;
  localparam logic [2:0] AUX_LAST    = 3'd7;
  localparam logic [2:0] CNT_MARK1   = 3'd1;
  localparam logic [2:0] CNT_FN_LO   = 3'd2;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [AUX_W-1:0]    aux_word_t;
  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [SLOT_W-1:0]   slot_t;

endpackage
`default_nettype wire

[rtl/sfp_in_if.sv]
`default_nettype none
interface sfp_in_if;
  import sfp_pkg::*;

  logic      valid;
  logic      ready;
  sample_t   sample_a;
  sample_t   sample_b;
  aux_word_t accel_x;
  aux_word_t accel_y;
  aux_word_t accel_z;
  aux_word_t battery_level;

  modport source (
    output valid, sample_a, sample_b, accel_x, accel_y, accel_z, battery_level,
    input  ready
  );
  modport sink (
    input  valid, sample_a, sample_b, accel_x, accel_y, accel_z, battery_level,
    output ready
  );
endinterface
`default_nettype wire

[rtl/sfp_out_if.sv]
`default_nettype none
interface sfp_out_if;
  import sfp_pkg::*;

  logic  valid;
  logic  ready;
  byte_t frame_byte;
  logic  frame_end;

  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink (input valid, frame_byte, frame_end, output ready);
endinterface
`default_nettype wire

[rtl/sensor_frame_packer_unit.sv]
`default_nettype none
// an accepted item is first loaded into the sample shifter and state register, then the first
// word goes into the output register once that is free; each item is sent through the byte
// shifters, the first of a frame after the header, the last ahead of held samples, aux and stop
// a new item is taken once the last word of the previous one sits in the output register
// reset clears sequencer, frame counter, slot and output valid; held samples are not cleared
module sensor_frame_packer_unit (
  input wire logic clk,
  input wire logic rst_n,
  sfp_in_if.sink   in_chan,
  sfp_out_if.source out_chan
);
  import sfp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_HDR  = 6'b000010,
    S_A    = 6'b000100,
    S_B    = 6'b001000,
    S_AUX  = 6'b010000,
    S_STOP = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [AUX_W-1:0]       frame_number_r, frame_number_nxt;
  slot_t                  slot_r, slot_nxt;
  slot_t                  bidx_r, bidx_nxt;
  logic                   last_r, last_nxt;
  logic [2:0]             cnt_r, cnt_nxt;
  sample_t                sh_r, sh_nxt;
  logic [4*AUX_W-1:0]     aux_r, aux_nxt;
  logic                   out_valid_r, out_valid_nxt;
  byte_t                  out_byte_r, out_byte_nxt;
  logic                   out_end_r, out_end_nxt;
  sample_t                held_r [SAMPLES_PER_FRAME];

  logic accept;
  logic emit;
  logic slot_last;

  assign in_chan.ready       = (state_r == S_IDLE);
  assign accept              = in_chan.valid && in_chan.ready;
  assign emit                = !out_valid_r || out_chan.ready;
  assign slot_last           = (slot_r == slot_t'(SAMPLES_PER_FRAME - 1));
  assign out_chan.valid      = out_valid_r;
  assign out_chan.frame_byte = out_byte_r;
  assign out_chan.frame_end  = out_end_r;

  always_comb begin
    state_nxt        = state_r;
    frame_number_nxt = frame_number_r;
    slot_nxt         = slot_r;
    bidx_nxt         = bidx_r;
    last_nxt         = last_r;
    cnt_nxt          = cnt_r;
    sh_nxt           = sh_r;
    aux_nxt          = aux_r;
    out_valid_nxt    = out_valid_r && !out_chan.ready;
    out_byte_nxt     = out_byte_r;
    out_end_nxt      = out_end_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          sh_nxt   = in_chan.sample_a;
          aux_nxt  = {in_chan.battery_level, in_chan.accel_z, in_chan.accel_y,
                      in_chan.accel_x};
          last_nxt = slot_last;
          slot_nxt = slot_last ? '0 : slot_r + slot_t'(1);
          cnt_nxt  = '0;
          state_nxt = (slot_r == '0) ? S_HDR : S_A;
        end
      end
      S_HDR: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          out_end_nxt   = 1'b0;
          if (cnt_r <= CNT_MARK1) begin
            out_byte_nxt = START_MARK;
          end else if (cnt_r == CNT_FN_LO) begin
            out_byte_nxt = frame_number_r[BYTE_W-1:0];
          end else begin
            out_byte_nxt = frame_number_r[2*BYTE_W-1:BYTE_W];
          end
          if (cnt_r == HDR_LAST) begin
            cnt_nxt   = '0;
            state_nxt = S_A;
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
      end
      S_A, S_B: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          out_end_nxt   = 1'b0;
          out_byte_nxt  = sh_r[BYTE_W-1:0];
          sh_nxt        = {{BYTE_W{1'b0}}, sh_r[SAMPLE_W-1:BYTE_W]};
          if (cnt_r == SAMPLE_LAST) begin
            cnt_nxt = '0;
            if (state_r == S_A) begin
              if (last_r) begin
                state_nxt = S_B;
                bidx_nxt  = '0;
                sh_nxt    = held_r[0];
              end else begin
                state_nxt = S_IDLE;
              end
            end else if (bidx_r == slot_t'(SAMPLES_PER_FRAME - 1)) begin
              state_nxt = S_AUX;
            end else begin
              bidx_nxt = bidx_r + slot_t'(1);
              sh_nxt   = held_r[bidx_r + slot_t'(1)];
            end
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
      end
      S_AUX: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          out_end_nxt   = 1'b0;
          out_byte_nxt  = aux_r[BYTE_W-1:0];
          aux_nxt       = {{BYTE_W{1'b0}}, aux_r[4*AUX_W-1:BYTE_W]};
          if (cnt_r == AUX_LAST) begin
            cnt_nxt   = '0;
            state_nxt = S_STOP;
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
      end
      S_STOP: begin
        if (emit) begin
          out_valid_nxt    = 1'b1;
          out_end_nxt      = 1'b1;
          out_byte_nxt     = STOP_MARK;
          frame_number_nxt = frame_number_r + AUX_W'(1);
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      frame_number_r <= '0;
      slot_r         <= '0;
      bidx_r         <= '0;
      last_r         <= 1'b0;
      cnt_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      frame_number_r <= frame_number_nxt;
      slot_r         <= slot_nxt;
      bidx_r         <= bidx_nxt;
      last_r         <= last_nxt;
      cnt_r          <= cnt_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    sh_r       <= sh_nxt;
    aux_r      <= aux_nxt;
    out_byte_r <= out_byte_nxt;
    out_end_r  <= out_end_nxt;
    if (accept) begin
      held_r[slot_r] <= in_chan.sample_b;
    end
  end

endmodule
`default_nettype wire

[test/sensor_frame_packer_unit_tb.sv]
`default_nettype none
module sensor_frame_packer_unit_tb;
  import sfp_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 60;
  localparam int PRINT_CAP   = 40;

  typedef struct packed {
    byte_t data;
    logic  stop;
  } frame_byte_t;

  logic clk;
  logic rst_n;

  sfp_in_if  in_chan ();
  sfp_out_if out_chan ();

  sensor_frame_packer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // predicted frame stream
  frame_byte_t frame_bytes_due[$];
  logic [15:0] frame_count = '0;
  int unsigned slot_pos    = 0;
  sample_t     held_b [SAMPLES_PER_FRAME];

  int unsigned mismatch_count = 0;
  int unsigned bytes_seen     = 0;
  int unsigned stall_cycles   = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_idle_pct  = 0;
  int unsigned hold_seq       = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) begin
      $display("mismatch at byte %0d: %s", bytes_seen, msg);
    end
    mismatch_count++;
  endtask

  function automatic void push_byte(input byte_t d, input logic stop);
    frame_byte_t fb;
    fb.data = d;
    fb.stop = stop;
    frame_bytes_due.push_back(fb);
  endfunction

  function automatic void push_sample(input sample_t s);
    push_byte(s[7:0], 1'b0);
    push_byte(s[15:8], 1'b0);
    push_byte(s[23:16], 1'b0);
  endfunction

  function automatic void push_word(input aux_word_t w);
    push_byte(w[7:0], 1'b0);
    push_byte(w[15:8], 1'b0);
  endfunction

  function automatic void pack_sample(input sample_t a, input sample_t b, input aux_word_t x,
                                      input aux_word_t y, input aux_word_t z,
                                      input aux_word_t bat);
    if (slot_pos == 0) begin
      push_byte(START_MARK, 1'b0);
      push_byte(START_MARK, 1'b0);
      push_byte(frame_count[7:0], 1'b0);
      push_byte(frame_count[15:8], 1'b0);
    end
    push_sample(a);
    held_b[slot_pos] = b;
    slot_pos++;
    if (slot_pos == SAMPLES_PER_FRAME) begin
      for (int i = 0; i < SAMPLES_PER_FRAME; i++) begin
        push_sample(held_b[i]);
      end
      push_word(x);
      push_word(y);
      push_word(z);
      push_word(bat);
      push_byte(STOP_MARK, 1'b1);
      frame_count = frame_count + 16'd1;
      slot_pos = 0;
    end
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return sample_t'(1) << $urandom_range(SAMPLE_W-1);
      3: return ~(sample_t'(1) << $urandom_range(SAMPLE_W-1));
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic aux_word_t pick_aux();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return aux_word_t'(1) << $urandom_range(AUX_W-1);
      3: return ~(aux_word_t'(1) << $urandom_range(AUX_W-1));
      default: return aux_word_t'($urandom);
    endcase
  endfunction

  // leaves valid high on return, so back to back words need no gap
  task automatic send_sample(input sample_t a, input sample_t b, input aux_word_t x,
                             input aux_word_t y, input aux_word_t z, input aux_word_t bat);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.sample_a      <= a;
    in_chan.sample_b      <= b;
    in_chan.accel_x       <= x;
    in_chan.accel_y       <= y;
    in_chan.accel_z       <= z;
    in_chan.battery_level <= bat;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    pack_sample(a, b, x, y, z, bat);
  endtask

  task automatic wait_frames_out();
    in_chan.valid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_frames();
    sample_t corner_samples [10];
    int k;
    corner_samples = '{24'h000000, 24'hFFFFFF, 24'h000001, 24'h800000, 24'h0000FF,
                       24'h00FF00, 24'hFF0000, 24'h555555, 24'hAAAAAA, 24'h123456};
    src_idle_pct = 0;
    sink_idle_pct <= 0;
    // aux words on non-final samples are random or all ones and must be ignored
    for (int i = 0; i < SAMPLES_PER_FRAME; i++) begin
      k = i % 10;
      if (i == SAMPLES_PER_FRAME - 1) begin
        send_sample(corner_samples[k], ~corner_samples[k], 16'h0000, 16'hFFFF, 16'h00FF,
                    16'hFF00);
      end else begin
        send_sample(corner_samples[k], ~corner_samples[k], pick_aux(), pick_aux(), pick_aux(),
                    pick_aux());
      end
    end
    for (int i = 0; i < SAMPLES_PER_FRAME; i++) begin
      k = i % 10;
      if (i == SAMPLES_PER_FRAME - 1) begin
        send_sample(corner_samples[9-k], corner_samples[k], 16'hFFFF, 16'h0000, 16'hFF00,
                    16'h00FF);
      end else begin
        send_sample(corner_samples[9-k], corner_samples[k], 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF);
      end
    end
    wait_frames_out();
  endtask

  task automatic test_random_frames(input int unsigned src_pct, input int unsigned sink_pct,
                                    input int unsigned count);
    src_idle_pct = src_pct;
    sink_idle_pct <= sink_pct;
    repeat (count) begin
      send_sample(pick_sample(), pick_sample(), pick_aux(), pick_aux(), pick_aux(), pick_aux());
    end
    wait_frames_out();
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_idle_pct <= 0;
    repeat (3) begin
      send_sample(pick_sample(), pick_sample(), pick_aux(), pick_aux(), pick_aux(), pick_aux());
    end
    // receiver stalls while the sender keeps offering
    hold_seq <= hold_seq + 1;
    repeat (2 * SAMPLES_PER_FRAME) begin
      send_sample(pick_sample(), pick_sample(), pick_aux(), pick_aux(), pick_aux(), pick_aux());
    end
    wait_frames_out();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen      <= hold_seq;
      hold_left      <= HOLD_CYCLES;
      out_chan.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left      <= hold_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin : check_bytes
    frame_byte_t due;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (frame_bytes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h end %b", out_chan.frame_byte,
                                  out_chan.frame_end));
      end else begin
        due = frame_bytes_due.pop_front();
        if (out_chan.frame_byte !== due.data) begin
          report_mismatch($sformatf("frame_byte %02h, want %02h", out_chan.frame_byte,
                                    due.data));
        end
        if (out_chan.frame_end !== due.stop) begin
          report_mismatch($sformatf("frame_end %b, want %b", out_chan.frame_end, due.stop));
        end
      end
      bytes_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("FAIL sensor_frame_packer_unit");
      $finish;
    end
  end

  initial begin
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.sample_a      = '0;
    in_chan.sample_b      = '0;
    in_chan.accel_x       = '0;
    in_chan.accel_y       = '0;
    in_chan.accel_z       = '0;
    in_chan.battery_level = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_random_frames(10, 59, 76);
    test_random_frames(59, 10, 76);
    test_random_frames(0, 0, 76);
    test_backpressure();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (frame_bytes_due.size() != 0) begin
      report_mismatch($sformatf("%0d bytes never arrived", frame_bytes_due.size()));
    end
    if (mismatch_count == 0) begin
      $display("PASS sensor_frame_packer_unit");
    end else begin
      $display("FAIL sensor_frame_packer_unit");
    end
    $finish;
  end

endmodule
`default_nettype wire
